[rtl/point_triangle_sq_distance_macros.svh]
// Assertion helpers used by the file that checks the pipeline.
`ifndef POINT_TRIANGLE_SQ_DISTANCE_MACROS_SVH
`define POINT_TRIANGLE_SQ_DISTANCE_MACROS_SVH

// Checked only while the block is out of reset.
`define PTSD_ASSERT_RST(lbl, expr, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) expr) else $error(msg);

// Checked at every edge, reset included.
`define PTSD_ASSERT_ANY(lbl, expr, msg) \
  lbl: assert property (@(posedge clk_i) expr) else $error(msg);

`endif

[rtl/ptsd_pkg.sv]
package ptsd_pkg;

  localparam int COORD_W   = 20;
  localparam int DIFF_W    = COORD_W + 1;
  localparam int PROD_W    = 2 * DIFF_W;
  localparam int GRAM_W    = PROD_W + 2;
  localparam int NRM_W     = PROD_W + 1;
  localparam int EXT_W     = GRAM_W + 2;
  localparam int WIDE_W    = 90;
  localparam int ND_W      = 66;
  localparam int MUL_W     = 66;
  localparam int MULR_W    = 2 * MUL_W;
  localparam int MUL_LIMBS = 3;
  localparam int LIMB_W    = MUL_W / MUL_LIMBS;
  localparam int MUL_STAGES = 3;
  localparam int GRAM_STAGES = 3;
  localparam int DEN_W     = 88;
  localparam int NUM_W     = 128;
  localparam int SQ_W      = 44;
  localparam int QUOT_W    = SQ_W + 1;
  localparam int REG_W     = 3;

  // Accept edge to the edge at which the result is sampled.
  localparam int LATENCY = GRAM_STAGES + 2 * MUL_STAGES + QUOT_W + 5;

  localparam logic [SQ_W-1:0] SQ_MAX = {SQ_W{1'b1}};
  localparam logic signed [MUL_W-1:0] MUL_ONE = MUL_W'(1);

  localparam logic [REG_W-1:0] REG_INTERIOR  = 3'd0;
  localparam logic [REG_W-1:0] REG_FAR_EDGE  = 3'd1;
  localparam logic [REG_W-1:0] REG_S_NEG_FAR = 3'd2;
  localparam logic [REG_W-1:0] REG_S_NEG     = 3'd3;
  localparam logic [REG_W-1:0] REG_ST_NEG    = 3'd4;
  localparam logic [REG_W-1:0] REG_T_NEG     = 3'd5;
  localparam logic [REG_W-1:0] REG_T_NEG_FAR = 3'd6;

  typedef struct packed {
    logic [2:0][COORD_W-1:0] p;
    logic [2:0][COORD_W-1:0] c0;
    logic [2:0][COORD_W-1:0] c1;
    logic [2:0][COORD_W-1:0] c2;
  } ptsd_pts_t;

  typedef struct packed {
    logic                     valid;
    logic signed [GRAM_W-1:0] a00;
    logic signed [GRAM_W-1:0] a01;
    logic signed [GRAM_W-1:0] a11;
    logic signed [GRAM_W-1:0] b0;
    logic signed [GRAM_W-1:0] b1;
    logic signed [GRAM_W-1:0] c;
    logic [2:0][NRM_W-1:0]    n;
    logic [2:0][DIFF_W-1:0]   d;
  } ptsd_gram_t;

  typedef struct packed {
    logic                     valid;
    logic signed [GRAM_W-1:0] a00;
    logic signed [GRAM_W-1:0] a01;
    logic signed [GRAM_W-1:0] a11;
    logic signed [GRAM_W-1:0] b0;
    logic signed [GRAM_W-1:0] b1;
    logic signed [GRAM_W-1:0] c;
    logic signed [EXT_W-1:0]  dd;
    logic signed [EXT_W-1:0]  v1;
    logic signed [EXT_W-1:0]  v2;
    logic signed [WIDE_W-1:0] det;
    logic signed [WIDE_W-1:0] s;
    logic signed [WIDE_W-1:0] t;
    logic signed [ND_W-1:0]   nd;
  } ptsd_geo_t;

  typedef struct packed {
    logic                    valid;
    logic signed [MUL_W-1:0] x;
    logic signed [MUL_W-1:0] y;
    logic signed [MUL_W-1:0] z;
    logic [DEN_W-1:0]        den;
    logic [REG_W-1:0]        region;
    logic                    degen;
  } ptsd_op_t;

  typedef struct packed {
    logic              valid;
    logic              sat;
    logic              degen;
    logic [REG_W-1:0]  region;
    logic [DEN_W-1:0]  rem;
    logic [DEN_W-1:0]  den;
    logic [QUOT_W-1:0] lo;
    logic [QUOT_W-1:0] q;
  } ptsd_div_t;

endpackage

[rtl/ptsd_mul.sv]
module ptsd_mul (
  input  logic                                clk_i,
  input  logic signed [ptsd_pkg::MUL_W-1:0]   a_i,
  input  logic signed [ptsd_pkg::MUL_W-1:0]   b_i,
  output logic signed [ptsd_pkg::MULR_W-1:0]  p_o
);
  import ptsd_pkg::*;

  // Operands are cut into limbs; only the top limb carries the sign.
  logic signed [LIMB_W:0]     la [MUL_LIMBS];
  logic signed [LIMB_W:0]     lb [MUL_LIMBS];
  logic signed [2*LIMB_W+1:0] pp_q [MUL_LIMBS][MUL_LIMBS];
  logic signed [MULR_W-1:0]   row_d [MUL_LIMBS];
  logic signed [MULR_W-1:0]   row_q [MUL_LIMBS];
  logic signed [MULR_W-1:0]   p_d;
  logic signed [MULR_W-1:0]   p_q;

  always_comb begin
    for (int k = 0; k < MUL_LIMBS; k++) begin
      if (k == MUL_LIMBS - 1) begin
        la[k] = $signed({a_i[MUL_W-1], a_i[k*LIMB_W +: LIMB_W]});
        lb[k] = $signed({b_i[MUL_W-1], b_i[k*LIMB_W +: LIMB_W]});
      end else begin
        la[k] = $signed({1'b0, a_i[k*LIMB_W +: LIMB_W]});
        lb[k] = $signed({1'b0, b_i[k*LIMB_W +: LIMB_W]});
      end
    end
  end

  always_comb begin
    for (int i = 0; i < MUL_LIMBS; i++) begin
      row_d[i] = '0;
      for (int j = 0; j < MUL_LIMBS; j++) begin
        row_d[i] = row_d[i] + (MULR_W'(pp_q[i][j]) <<< (j * LIMB_W));
      end
    end
    p_d = '0;
    for (int i = 0; i < MUL_LIMBS; i++) begin
      p_d = p_d + (row_q[i] <<< (i * LIMB_W));
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < MUL_LIMBS; i++) begin
      for (int j = 0; j < MUL_LIMBS; j++) begin
        pp_q[i][j] <= la[i] * lb[j];
      end
      row_q[i] <= row_d[i];
    end
    p_q <= p_d;
  end

  assign p_o = p_q;

endmodule

[rtl/ptsd_gram.sv]
module ptsd_gram (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  valid_i,
  input  ptsd_pkg::ptsd_pts_t   pts_i,
  output ptsd_pkg::ptsd_gram_t  gram_o
);
  import ptsd_pkg::*;

  function automatic logic signed [DIFF_W-1:0] sub_c(input logic [COORD_W-1:0] a,
                                                     input logic [COORD_W-1:0] b);
    return $signed({a[COORD_W-1], a}) - $signed({b[COORD_W-1], b});
  endfunction

  function automatic logic signed [GRAM_W-1:0] sum3(input logic signed [PROD_W-1:0] a,
                                                    input logic signed [PROD_W-1:0] b,
                                                    input logic signed [PROD_W-1:0] c);
    return GRAM_W'(a) + GRAM_W'(b) + GRAM_W'(c);
  endfunction

  logic                     va_q, vb_q, vc_q;
  logic signed [DIFF_W-1:0] d_d [3];
  logic signed [DIFF_W-1:0] e0_d [3];
  logic signed [DIFF_W-1:0] e1_d [3];
  logic signed [DIFF_W-1:0] d_q [3];
  logic signed [DIFF_W-1:0] e0_q [3];
  logic signed [DIFF_W-1:0] e1_q [3];
  logic signed [DIFF_W-1:0] db_q [3];
  // Rows: a00, a01, a11, b0, b1, c.
  logic signed [PROD_W-1:0] pr_q [6][3];
  logic signed [PROD_W-1:0] cra_q [3];
  logic signed [PROD_W-1:0] crb_q [3];
  ptsd_gram_t               gram_q;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      d_d[i]  = sub_c(pts_i.c0[i], pts_i.p[i]);
      e0_d[i] = sub_c(pts_i.c1[i], pts_i.c0[i]);
      e1_d[i] = sub_c(pts_i.c2[i], pts_i.c0[i]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
      vc_q <= 1'b0;
    end else begin
      va_q <= valid_i;
      vb_q <= va_q;
      vc_q <= vb_q;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      d_q[i]  <= d_d[i];
      e0_q[i] <= e0_d[i];
      e1_q[i] <= e1_d[i];
      pr_q[0][i] <= e0_q[i] * e0_q[i];
      pr_q[1][i] <= e0_q[i] * e1_q[i];
      pr_q[2][i] <= e1_q[i] * e1_q[i];
      pr_q[3][i] <= d_q[i] * e0_q[i];
      pr_q[4][i] <= d_q[i] * e1_q[i];
      pr_q[5][i] <= d_q[i] * d_q[i];
      db_q[i] <= d_q[i];
      gram_q.d[i] <= db_q[i];
      gram_q.n[i] <= NRM_W'(cra_q[i]) - NRM_W'(crb_q[i]);
    end
    cra_q[0] <= e0_q[1] * e1_q[2];
    crb_q[0] <= e0_q[2] * e1_q[1];
    cra_q[1] <= e0_q[2] * e1_q[0];
    crb_q[1] <= e0_q[0] * e1_q[2];
    cra_q[2] <= e0_q[0] * e1_q[1];
    crb_q[2] <= e0_q[1] * e1_q[0];
    gram_q.valid <= 1'b0;
    gram_q.a00 <= sum3(pr_q[0][0], pr_q[0][1], pr_q[0][2]);
    gram_q.a01 <= sum3(pr_q[1][0], pr_q[1][1], pr_q[1][2]);
    gram_q.a11 <= sum3(pr_q[2][0], pr_q[2][1], pr_q[2][2]);
    gram_q.b0  <= sum3(pr_q[3][0], pr_q[3][1], pr_q[3][2]);
    gram_q.b1  <= sum3(pr_q[4][0], pr_q[4][1], pr_q[4][2]);
    gram_q.c   <= sum3(pr_q[5][0], pr_q[5][1], pr_q[5][2]);
  end

  always_comb begin
    gram_o       = gram_q;
    gram_o.valid = vc_q;
  end

endmodule

[rtl/ptsd_classify.sv]
module ptsd_classify (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  ptsd_pkg::ptsd_geo_t  geo_i,
  output ptsd_pkg::ptsd_op_t   op_o
);
  import ptsd_pkg::*;

  typedef enum logic [2:0] {
    K_V0, K_V1, K_V2, K_E01, K_E02, K_E12, K_IN
  } kind_e;

  kind_e                    kind;
  logic [REG_W-1:0]         region;
  logic                     degen, sneg, tneg, le, b0neg, b1neg, nb0_ge, nb1_ge;
  logic signed [WIDE_W:0]   st;
  logic signed [EXT_W-1:0]  a00, a01, a11, b0, b1;
  logic signed [EXT_W-1:0]  r2m0, r2m1, r2d, r6m0, r6m1, r6d, nn;
  ptsd_op_t                 op_d;
  ptsd_op_t                 op_q;
  logic                     v_q;

  always_comb begin
    a00 = EXT_W'(geo_i.a00);
    a01 = EXT_W'(geo_i.a01);
    a11 = EXT_W'(geo_i.a11);
    b0  = EXT_W'(geo_i.b0);
    b1  = EXT_W'(geo_i.b1);
    degen  = (geo_i.det == '0);
    sneg   = geo_i.s[WIDE_W-1];
    tneg   = geo_i.t[WIDE_W-1];
    st     = (WIDE_W+1)'(geo_i.s) + (WIDE_W+1)'(geo_i.t);
    le     = (st <= (WIDE_W+1)'(geo_i.det));
    b0neg  = geo_i.b0[GRAM_W-1];
    b1neg  = geo_i.b1[GRAM_W-1];
    nb0_ge = ((-b0) >= a00);
    nb1_ge = ((-b1) >= a11);
    r2m0   = a01 + b0;
    r2m1   = a11 + b1;
    r2d    = r2m1 - r2m0;
    r6m0   = a01 + b1;
    r6m1   = a00 + b0;
    r6d    = r6m1 - r6m0;
    // The far-edge projection parameter and the far-edge numerator term coincide.
    nn     = r2d;

    kind   = K_IN;
    region = REG_INTERIOR;
    if (le) begin
      if (sneg && tneg) begin
        region = REG_ST_NEG;
        if (b0neg) kind = nb0_ge ? K_V1 : K_E01;
        else if (!b1neg) kind = K_V0;
        else kind = nb1_ge ? K_V2 : K_E02;
      end else if (sneg) begin
        region = REG_S_NEG;
        if (!b1neg) kind = K_V0;
        else kind = nb1_ge ? K_V2 : K_E02;
      end else if (tneg) begin
        region = REG_T_NEG;
        if (!b0neg) kind = K_V0;
        else kind = nb0_ge ? K_V1 : K_E01;
      end
    end else if (sneg) begin
      region = REG_S_NEG_FAR;
      if (r2m1 > r2m0) kind = (r2d >= geo_i.dd) ? K_V1 : K_E12;
      else if (r2m1 <= 0) kind = K_V2;
      else if (!b1neg) kind = K_V0;
      else kind = K_E02;
    end else if (tneg) begin
      region = REG_T_NEG_FAR;
      if (r6m1 > r6m0) kind = (r6d >= geo_i.dd) ? K_V2 : K_E12;
      else if (r6m1 <= 0) kind = K_V1;
      else if (!b0neg) kind = K_V0;
      else kind = K_E01;
    end else begin
      region = REG_FAR_EDGE;
      if (nn <= 0) kind = K_V2;
      else kind = (nn >= geo_i.dd) ? K_V1 : K_E12;
    end
    if (degen) region = REG_INTERIOR;
  end

  // Every case reduces to x*y - z*z over a denominator.
  always_comb begin
    op_d        = '0;
    op_d.region = region;
    op_d.degen  = degen;
    op_d.y      = MUL_ONE;
    op_d.den    = DEN_W'(1);
    case (kind)
      K_V0: op_d.x = MUL_W'(geo_i.c);
      K_V1: op_d.x = MUL_W'(geo_i.v1);
      K_V2: op_d.x = MUL_W'(geo_i.v2);
      K_E01: begin
        op_d.x   = MUL_W'(geo_i.c);
        op_d.y   = MUL_W'(geo_i.a00);
        op_d.z   = MUL_W'(geo_i.b0);
        op_d.den = DEN_W'($unsigned(geo_i.a00));
      end
      K_E02: begin
        op_d.x   = MUL_W'(geo_i.c);
        op_d.y   = MUL_W'(geo_i.a11);
        op_d.z   = MUL_W'(geo_i.b1);
        op_d.den = DEN_W'($unsigned(geo_i.a11));
      end
      K_E12: begin
        op_d.x   = MUL_W'(geo_i.v2);
        op_d.y   = MUL_W'(geo_i.dd);
        op_d.z   = MUL_W'(nn);
        op_d.den = DEN_W'($unsigned(geo_i.dd));
      end
      default: begin
        op_d.x   = MUL_W'(geo_i.nd);
        op_d.y   = MUL_W'(geo_i.nd);
        op_d.den = geo_i.det[DEN_W-1:0];
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else begin
      v_q <= geo_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q <= op_d;
  end

  always_comb begin
    op_o       = op_q;
    op_o.valid = v_q;
  end

endmodule

[rtl/ptsd_div_stage.sv]
module ptsd_div_stage (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  ptsd_pkg::ptsd_div_t  stage_i,
  output ptsd_pkg::ptsd_div_t  stage_o
);
  import ptsd_pkg::*;

  logic [DEN_W:0] trial, diff;
  logic           take;
  ptsd_div_t      st_d;
  ptsd_div_t      st_q;
  logic           v_q;

  // One quotient bit: shift in the next dividend bit and subtract if it fits.
  always_comb begin
    trial = {stage_i.rem, stage_i.lo[QUOT_W-1]};
    diff  = trial - {1'b0, stage_i.den};
    take  = (trial >= {1'b0, stage_i.den});
    st_d     = stage_i;
    st_d.rem = take ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
    st_d.lo  = {stage_i.lo[QUOT_W-2:0], 1'b0};
    st_d.q   = {stage_i.q[QUOT_W-2:0], take};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else begin
      v_q <= stage_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    st_q <= st_d;
  end

  always_comb begin
    stage_o       = st_q;
    stage_o.valid = v_q;
  end

endmodule

[rtl/point_triangle_sq_distance.sv]
// Channel   Ports                                        Direction  Handshake
// -------   -------------------------------------------  ---------  -------------------
// command   point_*_i, corner0_*_i .. corner2_*_i         in         start / busy
// result    sq_distance_o, region_o, degenerate_o        out        done_o, one cycle
//
// One item is accepted per cycle; busy is high in reset and until ready_q is set.
// Each result passes through 3 Gram stages, two multiplier banks, 5 single stages
// with the output register and a 45-stage one-bit-per-stage divider.
// Reset clears the valid bits of every stage; the data registers are not reset.
// The receiver cannot stall, so nothing is ever held back inside the pipeline.
`include "point_triangle_sq_distance_macros.svh"

module point_triangle_sq_distance (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start,
  output logic                                busy,
  input  logic signed [ptsd_pkg::COORD_W-1:0] point_x_i,
  input  logic signed [ptsd_pkg::COORD_W-1:0] point_y_i,
  input  logic signed [ptsd_pkg::COORD_W-1:0] point_z_i,
  input  logic signed [ptsd_pkg::COORD_W-1:0] corner0_x_i,
  input  logic signed [ptsd_pkg::COORD_W-1:0] corner0_y_i,
  input  logic signed [ptsd_pkg::COORD_W-1:0] corner0_z_i,
  input  logic signed [ptsd_pkg::COORD_W-1:0] corner1_x_i,
  input  logic signed [ptsd_pkg::COORD_W-1:0] corner1_y_i,
  input  logic signed [ptsd_pkg::COORD_W-1:0] corner1_z_i,
  input  logic signed [ptsd_pkg::COORD_W-1:0] corner2_x_i,
  input  logic signed [ptsd_pkg::COORD_W-1:0] corner2_y_i,
  input  logic signed [ptsd_pkg::COORD_W-1:0] corner2_z_i,
  output logic                                done_o,
  output logic [ptsd_pkg::SQ_W-1:0]           sq_distance_o,
  output logic [ptsd_pkg::REG_W-1:0]          region_o,
  output logic                                degenerate_o
);
  import ptsd_pkg::*;

  logic                      ready_q;
  logic                      accept;
  ptsd_pts_t                 pts;
  ptsd_gram_t                gram;
  ptsd_gram_t                gram_dly_q [MUL_STAGES];
  logic [MUL_STAGES-1:0]     gv_q;
  ptsd_gram_t                gd;
  logic signed [MUL_W-1:0]   ma [9];
  logic signed [MUL_W-1:0]   mb [9];
  logic signed [MULR_W-1:0]  mp [9];
  ptsd_geo_t                 geo_d, geo_q, geo;
  logic                      dv_q;
  ptsd_op_t                  op;
  ptsd_op_t                  op_dly_q [MUL_STAGES];
  logic [MUL_STAGES-1:0]     ov_q;
  logic signed [MULR_W-1:0]  xy, zz;
  logic [NUM_W-1:0]          num_q;
  ptsd_op_t                  fmeta_q;
  logic                      fv_q;
  logic [NUM_W:0]            n2;
  logic [NUM_W-QUOT_W:0]     rem_init;
  ptsd_div_t                 div0_d, div0_q;
  logic                      gv0_q;
  ptsd_div_t                 chain [QUOT_W+1];
  ptsd_div_t                 last;
  logic [QUOT_W:0]           qp1;
  logic                      done_q;
  logic [SQ_W-1:0]           sq_q;
  logic [REG_W-1:0]          region_q;
  logic                      degen_q;

  assign busy   = !ready_q;
  assign accept = start && !busy;

  always_comb begin
    pts.p[0]  = point_x_i;
    pts.p[1]  = point_y_i;
    pts.p[2]  = point_z_i;
    pts.c0[0] = corner0_x_i;
    pts.c0[1] = corner0_y_i;
    pts.c0[2] = corner0_z_i;
    pts.c1[0] = corner1_x_i;
    pts.c1[1] = corner1_y_i;
    pts.c1[2] = corner1_z_i;
    pts.c2[0] = corner2_x_i;
    pts.c2[1] = corner2_y_i;
    pts.c2[2] = corner2_z_i;
  end

  ptsd_gram u_gram (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (accept),
    .pts_i   (pts),
    .gram_o  (gram)
  );

  // First multiplier bank: determinant, S, T and the normal against d.
  always_comb begin
    ma[0] = MUL_W'(gram.a00);  mb[0] = MUL_W'(gram.a11);
    ma[1] = MUL_W'(gram.a01);  mb[1] = MUL_W'(gram.a01);
    ma[2] = MUL_W'(gram.a01);  mb[2] = MUL_W'(gram.b1);
    ma[3] = MUL_W'(gram.a11);  mb[3] = MUL_W'(gram.b0);
    ma[4] = MUL_W'(gram.a01);  mb[4] = MUL_W'(gram.b0);
    ma[5] = MUL_W'(gram.a00);  mb[5] = MUL_W'(gram.b1);
    for (int i = 0; i < 3; i++) begin
      ma[6+i] = MUL_W'($signed(gram.n[i]));
      mb[6+i] = MUL_W'($signed(gram.d[i]));
    end
  end

  for (genvar g = 0; g < 9; g++) begin : g_mul1
    ptsd_mul u_mul (
      .clk_i (clk_i),
      .a_i   (ma[g]),
      .b_i   (mb[g]),
      .p_o   (mp[g])
    );
  end

  always_ff @(posedge clk_i) begin
    gram_dly_q[0] <= gram;
    for (int k = 1; k < MUL_STAGES; k++) begin
      gram_dly_q[k] <= gram_dly_q[k-1];
    end
  end

  assign gd = gram_dly_q[MUL_STAGES-1];

  always_comb begin
    geo_d       = '0;
    geo_d.a00   = gd.a00;
    geo_d.a01   = gd.a01;
    geo_d.a11   = gd.a11;
    geo_d.b0    = gd.b0;
    geo_d.b1    = gd.b1;
    geo_d.c     = gd.c;
    geo_d.dd    = EXT_W'(gd.a00) - EXT_W'(gd.a01) - EXT_W'(gd.a01) + EXT_W'(gd.a11);
    geo_d.v1    = EXT_W'(gd.a00) + EXT_W'(gd.b0) + EXT_W'(gd.b0) + EXT_W'(gd.c);
    geo_d.v2    = EXT_W'(gd.a11) + EXT_W'(gd.b1) + EXT_W'(gd.b1) + EXT_W'(gd.c);
    geo_d.det   = WIDE_W'(mp[0] - mp[1]);
    geo_d.s     = WIDE_W'(mp[2] - mp[3]);
    geo_d.t     = WIDE_W'(mp[4] - mp[5]);
    geo_d.nd    = ND_W'(mp[6] + mp[7] + mp[8]);
  end

  always_ff @(posedge clk_i) begin
    geo_q <= geo_d;
  end

  always_comb begin
    geo       = geo_q;
    geo.valid = dv_q;
  end

  ptsd_classify u_classify (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .geo_i  (geo),
    .op_o   (op)
  );

  ptsd_mul u_mul_xy (
    .clk_i (clk_i),
    .a_i   (op.x),
    .b_i   (op.y),
    .p_o   (xy)
  );

  ptsd_mul u_mul_zz (
    .clk_i (clk_i),
    .a_i   (op.z),
    .b_i   (op.z),
    .p_o   (zz)
  );

  always_ff @(posedge clk_i) begin
    op_dly_q[0] <= op;
    for (int k = 1; k < MUL_STAGES; k++) begin
      op_dly_q[k] <= op_dly_q[k-1];
    end
    num_q   <= NUM_W'(xy - zz);
    fmeta_q <= op_dly_q[MUL_STAGES-1];
    div0_q  <= div0_d;
  end

  // Quotient of 2*num/den; it overflows exactly when the top part is not below den.
  always_comb begin
    n2            = {num_q, 1'b0};
    rem_init      = n2[NUM_W:QUOT_W];
    div0_d        = '0;
    div0_d.rem    = DEN_W'(rem_init);
    div0_d.den    = fmeta_q.den;
    div0_d.lo     = n2[QUOT_W-1:0];
    div0_d.sat    = (DEN_W'(rem_init) >= fmeta_q.den);
    div0_d.degen  = fmeta_q.degen;
    div0_d.region = fmeta_q.region;
  end

  always_comb begin
    chain[0]       = div0_q;
    chain[0].valid = gv0_q;
  end

  for (genvar k = 0; k < QUOT_W; k++) begin : g_div
    ptsd_div_stage u_stage (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .stage_i (chain[k]),
      .stage_o (chain[k+1])
    );
  end

  assign last = chain[QUOT_W];
  assign qp1  = {1'b0, last.q} + (QUOT_W+1)'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ready_q <= 1'b0;
      gv_q    <= '0;
      dv_q    <= 1'b0;
      ov_q    <= '0;
      fv_q    <= 1'b0;
      gv0_q   <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      ready_q <= 1'b1;
      gv_q    <= {gv_q[MUL_STAGES-2:0], gram.valid};
      dv_q    <= gv_q[MUL_STAGES-1];
      ov_q    <= {ov_q[MUL_STAGES-2:0], op.valid};
      fv_q    <= ov_q[MUL_STAGES-1];
      gv0_q   <= fv_q;
      done_q  <= last.valid;
    end
  end

  // Round half up: (q + 1) / 2 where q carries one extra fraction bit.
  // A carry out of the top bit means the rounded value no longer fits.
  always_ff @(posedge clk_i) begin
    sq_q     <= (last.sat || last.degen || qp1[QUOT_W]) ? SQ_MAX : qp1[SQ_W:1];
    region_q <= last.region;
    degen_q  <= last.degen;
  end

  assign done_o        = done_q;
  assign sq_distance_o = sq_q;
  assign region_o      = region_q;
  assign degenerate_o  = degen_q;

  `PTSD_ASSERT_RST(a_latency, (start && !busy) |-> ##LATENCY done_o, "lost transfer")
  `PTSD_ASSERT_RST(a_no_extra, done_o |-> $past(start && !busy, LATENCY), "spurious result")
  `PTSD_ASSERT_RST(a_degen_out, (done_o && degenerate_o) |-> ((sq_distance_o == SQ_MAX) && (region_o == REG_INTERIOR)), "bad degenerate result")
  `PTSD_ASSERT_ANY(a_rem_below, (last.valid && !last.sat) |-> (last.rem < last.den), "divider remainder out of range")

endmodule
